[sv/pslin_pkg.sv]
// pslin_pkg: shared types, constants and helpers for the premultiplied
// srgb to linear pixel converter. No dependencies.
package pslin_pkg;

	localparam int OUT_BITS = 16;
	localparam int QB = 30;
	localparam int DIV_STEPS = QB + 1;
	localparam int SRCH_STEPS = QB + 1;
	// input reg, divider, square, 4 stages per search step, tail of six stages
	localparam int CHAN_LAT = 1 + DIV_STEPS + 1 + 4 * SRCH_STEPS + 6;

	localparam longint unsigned FULL = (64'd1 << OUT_BITS) - 64'd1;

	typedef logic [OUT_BITS-1:0] lin_t;
	typedef logic [QB:0] q_t;

	localparam q_t QONE = q_t'(1) << QB;
	localparam logic [2*QB+1:0] QHALF = (2*QB+2)'(1) << (QB - 1);

	typedef enum logic [1:0] {
		KIND_LIN,
		KIND_ONE,
		KIND_POW
	} kind_t;

	typedef struct packed {
		logic [7:0] a;
		kind_t kind;
		lin_t linv;
	} side_t;

	typedef lin_t lin_tab_t [16];
	typedef lin_t alpha_tab_t [256];

	// linear segment, only reached for colour bytes up to ten
	function automatic lin_tab_t mk_lin_tab();
		lin_tab_t t;
		for (int i = 0; i < 16; i++) begin
			t[i] = lin_t'((longint'(i) * 100 * FULL + 164730) / 329460);
		end
		return t;
	endfunction

	function automatic alpha_tab_t mk_alpha_tab();
		alpha_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = lin_t'((longint'(i) * FULL + 127) / 255);
		end
		return t;
	endfunction

	localparam lin_tab_t LIN_TAB = mk_lin_tab();
	localparam alpha_tab_t ALPHA_TAB = mk_alpha_tab();

	// q30 product, rounded to nearest
	function automatic q_t qmul(input q_t x, input q_t y);
		logic [2*QB+1:0] p;
		p = (2*QB+2)'(x) * (2*QB+2)'(y) + QHALF;
		return q_t'(p >> QB);
	endfunction

endpackage

[sv/pslin_in_if.sv]
// pslin_in_if: valid/ready channel carrying one premultiplied srgb pixel
// depends on nothing
interface pslin_in_if;
	logic valid;
	logic ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [7:0] alpha_in;

	modport source(output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink(input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

[sv/pslin_out_if.sv]
// pslin_out_if: valid/ready channel carrying one linear premultiplied pixel
// depends on pslin_pkg
interface pslin_out_if import pslin_pkg::*; ;
	logic valid;
	logic ready;
	lin_t red_lin;
	lin_t green_lin;
	lin_t blue_lin;
	lin_t alpha_lin;

	modport source(output valid, red_lin, green_lin, blue_lin, alpha_lin, input ready);
	modport sink(input valid, red_lin, green_lin, blue_lin, alpha_lin, output ready);
endinterface

[sv/pslin_chan.sv]
// pslin_chan: pipelined decode of one colour channel to linear premultiplied
// depends on pslin_pkg
module pslin_chan import pslin_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] c,
	input  logic [7:0] a,
	output lin_t       res,
	output logic [7:0] a_out
);

	localparam int RW = 19 + QB + 1;
	localparam int PW = QB + 1 + 8;
	localparam int ZW = PW + OUT_BITS + 1;
	localparam int WW = ZW - QB;
	localparam logic [ZW-1:0] ZRND = ZW'(255) << (QB - 1);

	typedef struct packed {
		side_t side;
		logic [RW-1:0] rem;
		logic [18:0] den;
		q_t q;
	} div_t;

	typedef struct packed {
		side_t side;
		q_t y2;
		q_t lo;
		q_t hi;
		q_t mid;
		q_t r2;
		q_t r4;
		logic run;
	} srch_t;

	div_t d_s [DIV_STEPS+1];
	srch_t st_s [SRCH_STEPS+1];
	srch_t sa_s [SRCH_STEPS];
	srch_t sb_s [SRCH_STEPS];
	srch_t sc_s [SRCH_STEPS];

	side_t lin_side_s, p_side_s, w_side_s, q_side_s, o_side_s;
	q_t lin_s;
	logic [PW-1:0] p_s;
	logic [WW-1:0] w_s, wq_s, q0r_s;
	logic [15:0] r_s;
	lin_t res_s;

	// entry: classify and set up the q30 quotient
	logic [18:0] num, den;
	side_t side_in;
	div_t d_in;
	always_comb begin
		num = 19'(c) * 19'd1000 + 19'(a) * 19'd55;
		den = 19'(a) * 19'd1055;
		side_in.a = a;
		side_in.linv = LIN_TAB[c[3:0]];
		if (c >= a) begin
			side_in.kind = KIND_ONE;
		end else if (25'(c) * 25'd100000 <= 25'(a) * 25'd4045) begin
			side_in.kind = KIND_LIN;
		end else begin
			side_in.kind = KIND_POW;
		end
		d_in.side = side_in;
		d_in.rem = (RW'(num) << QB) + RW'(den >> 1);
		d_in.den = den;
		d_in.q = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= d_in;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int SH = DIV_STEPS - 1 - k;
		logic [RW-1:0] trial;
		div_t d_n;
		assign trial = RW'(d_s[k].den) << SH;
		always_comb begin
			d_n = d_s[k];
			if (d_s[k].rem >= trial) begin
				d_n.rem = d_s[k].rem - trial;
				d_n.q[SH] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1] <= d_n;
			end
		end
	end

	srch_t st_in;
	always_comb begin
		st_in = '0;
		st_in.side = d_s[DIV_STEPS].side;
		st_in.y2 = qmul(d_s[DIV_STEPS].q, d_s[DIV_STEPS].q);
		st_in.hi = QONE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= st_in;
		end
	end

	// fifth root of y^2 by bisection, four stages per step
	for (genvar j = 0; j < SRCH_STEPS; j++) begin : g_srch
		q_t p;
		srch_t sa_n, sb_n, sc_n, st_n;
		assign p = qmul(sc_s[j].r4, sc_s[j].mid);
		always_comb begin
			sa_n = st_s[j];
			sa_n.mid = q_t'(((QB+2)'(st_s[j].lo) + (QB+2)'(st_s[j].hi) + (QB+2)'(1)) >> 1);
			sa_n.run = st_s[j].lo < st_s[j].hi;

			sb_n = sa_s[j];
			sb_n.r2 = qmul(sa_s[j].mid, sa_s[j].mid);

			sc_n = sb_s[j];
			sc_n.r4 = qmul(sb_s[j].r2, sb_s[j].r2);

			st_n = sc_s[j];
			if (sc_s[j].run) begin
				if (p <= sc_s[j].y2) begin
					st_n.lo = sc_s[j].mid;
				end else begin
					st_n.hi = sc_s[j].mid - q_t'(1);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sa_s[j] <= sa_n;
				sb_s[j] <= sb_n;
				sc_s[j] <= sc_n;
				st_s[j+1] <= st_n;
			end
		end
	end

	// tail: scale by alpha and full scale, divide by 255 q30
	logic [ZW-1:0] z;
	logic [WW-1:0] q0;
	logic [WW-1:0] rq;
	always_comb begin
		z = (ZW'(p_s) << OUT_BITS) - ZW'(p_s) + ZRND;
		q0 = (wq_s + (wq_s >> 8) + (wq_s >> 16) + (wq_s >> 24)) >> 8;
		rq = q0r_s + WW'((17'(r_s) + 17'(r_s >> 8) + 17'd1) >> 8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_side_s <= st_s[SRCH_STEPS].side;
			lin_s <= (st_s[SRCH_STEPS].side.kind == KIND_ONE) ? QONE
				: qmul(st_s[SRCH_STEPS].y2, st_s[SRCH_STEPS].lo);

			p_side_s <= lin_side_s;
			p_s <= PW'(lin_s) * PW'(lin_side_s.a);

			w_side_s <= p_side_s;
			w_s <= WW'(z >> QB);

			q_side_s <= w_side_s;
			wq_s <= w_s;

			o_side_s <= q_side_s;
			q0r_s <= q0;
			r_s <= 16'(wq_s - (q0 << 8) + q0);

			if (o_side_s.a == 8'd0) begin
				res_s <= '0;
			end else if (o_side_s.kind == KIND_LIN) begin
				res_s <= o_side_s.linv;
			end else begin
				res_s <= lin_t'(rq);
			end
			a_out <= o_side_s.a;
		end
	end

	assign res = res_s;

endmodule

[sv/premultiplied_srgb_to_linear_pixel.sv]
// premultiplied_srgb_to_linear_pixel: an accepted word passes the channel pipeline stages
// and then the output register, from which its result word can be taken
// throughput one word per cycle; the whole pipeline moves on one enable
// and holds only while a finished word waits behind a full output register not taken
// reset clears the pipeline valid bits and the output valid; payload is not reset
// depends on pslin_pkg, pslin_in_if, pslin_out_if, pslin_chan
module premultiplied_srgb_to_linear_pixel import pslin_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pslin_in_if.sink pix,
	pslin_out_if.source lin
);

	// valid bit for each pipeline stage of the channel units
	logic v_s [CHAN_LAT];
	logic o_v_q;
	lin_t r_res, g_res, b_res;
	logic [7:0] a_end, g_a_end, b_a_end;
	lin_t o_r_q, o_g_q, o_b_q, o_a_q;
	logic en;

	// the pipeline only stops when its last word cannot leave
	assign en = !(v_s[CHAN_LAT-1] && o_v_q && !lin.ready);
	assign pix.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHAN_LAT; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= pix.valid;
			for (int k = 1; k < CHAN_LAT; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	// one decoder per colour channel, all in lock step
	pslin_chan u_red (
		.clk(clk), .en(en), .c(pix.red_in), .a(pix.alpha_in),
		.res(r_res), .a_out(a_end)
	);
	pslin_chan u_green (
		.clk(clk), .en(en), .c(pix.green_in), .a(pix.alpha_in),
		.res(g_res), .a_out(g_a_end)
	);
	pslin_chan u_blue (
		.clk(clk), .en(en), .c(pix.blue_in), .a(pix.alpha_in),
		.res(b_res), .a_out(b_a_end)
	);

	// output register: control under reset, payload loaded with the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
		end else if (en && v_s[CHAN_LAT-1]) begin
			o_v_q <= 1'b1;
		end else if (lin.ready) begin
			o_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s[CHAN_LAT-1]) begin
			o_r_q <= r_res;
			o_g_q <= g_res;
			o_b_q <= b_res;
			// normalised alpha straight from a table of the byte
			o_a_q <= ALPHA_TAB[a_end];
		end
	end

	assign lin.valid = o_v_q;
	assign lin.red_lin = o_r_q;
	assign lin.green_lin = o_g_q;
	assign lin.blue_lin = o_b_q;
	assign lin.alpha_lin = o_a_q;

endmodule
